FILE: rtl/qnorm_pkg.sv
// Shared constants and types for the quaternion normalizer.
package qnorm_pkg;

  // Number of quaternion components handled side by side.
  localparam int NLANE = 4;

  // Port field widths.
  localparam int IN_W  = 18;
  localparam int OUT_W = 16;
  localparam int CFG_W = 20;

  // Magnitude of one component, its square and the sum of four squares.
  localparam int MAG_W = IN_W;
  localparam int MSQ_W = 2 * IN_W - 1;
  localparam int SUM_W = MSQ_W + 2;

  // Default fraction width and threshold reset value.
  localparam int FRAC_BITS_DEF = 14;
  localparam logic [CFG_W-1:0] MIN_NORM_RESET = 20'd2684;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic             vld;
    logic             degen;
    logic [NLANE-1:0] neg;
  } ctl_t;

endpackage

FILE: rtl/qnorm_front.sv
// Front end: component magnitudes, squares, squared norm and threshold test.
module qnorm_front
  import qnorm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int W         = SUM_W + 2 * FRAC_BITS_DEF + 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [IN_W-1:0]  in_comp [NLANE],
  input  logic        [CFG_W-1:0] min_norm_sq,
  output ctl_t                    ctl,
  output logic        [SUM_W-1:0] sum,
  output logic        [W-1:0]     rem [NLANE]
);

  ctl_t             ctl_a;
  logic [MSQ_W-1:0] msq [NLANE];
  logic [MAG_W-1:0] mag [NLANE];
  logic [2*MAG_W-1:0] sq_full [NLANE];
  logic [SUM_W-1:0] sum_next;
  logic             degen_next;

  // Absolute value and square of each component.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mag[i]     = in_comp[i][IN_W-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
      sq_full[i] = mag[i] * mag[i];
    end
  end

  // First stage: registered squares and signs.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a.vld   <= in_vld;
      ctl_a.degen <= 1'b0;
      for (int i = 0; i < NLANE; i++) begin
        ctl_a.neg[i] <= in_comp[i][IN_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NLANE; i++) begin
        msq[i] <= sq_full[i][MSQ_W-1:0];
      end
    end
  end

  // Squared norm and the identity test; a zero norm is always degenerate.
  always_comb begin
    sum_next = SUM_W'(msq[0]) + SUM_W'(msq[1]) + SUM_W'(msq[2]) + SUM_W'(msq[3]);
    degen_next = (sum_next == '0) || (sum_next < SUM_W'(min_norm_sq));
  end

  // Second stage: norm, flag and starting remainders for the root search.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.vld   <= ctl_a.vld;
      ctl.degen <= degen_next;
      ctl.neg   <= ctl_a.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
      for (int i = 0; i < NLANE; i++) begin
        rem[i] <= W'(msq[i]) << (2 * FRAC_BITS + 2);
      end
    end
  end

endmodule

FILE: rtl/qnorm_step.sv
// One bit of the restoring square-root search, for all four lanes.
module qnorm_step
  import qnorm_pkg::*;
#(
  parameter int W  = SUM_W + 2 * FRAC_BITS_DEF + 4,
  parameter int NB = FRAC_BITS_DEF + 2,
  parameter int K  = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ctl_t             ctl_in,
  input  logic [SUM_W-1:0] sum_in,
  input  logic [W-1:0]     rem_in  [NLANE],
  input  logic [W-1:0]     prod_in [NLANE],
  input  logic [NB-1:0]    root_in [NLANE],
  output ctl_t             ctl_out,
  output logic [SUM_W-1:0] sum_out,
  output logic [W-1:0]     rem_out  [NLANE],
  output logic [W-1:0]     prod_out [NLANE],
  output logic [NB-1:0]    root_out [NLANE]
);

  logic [W-1:0]  trial     [NLANE];
  logic          fits      [NLANE];
  logic [W-1:0]  rem_next  [NLANE];
  logic [W-1:0]  prod_next [NLANE];
  logic [NB-1:0] root_next [NLANE];

  // Setting bit K of root n raises n*n*S by 2^(K+1)*n*S + 2^(2K)*S; prod holds n*S.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      trial[i]     = (prod_in[i] << (K + 1)) + (W'(sum_in) << (2 * K));
      fits[i]      = (trial[i] <= rem_in[i]);
      rem_next[i]  = fits[i] ? (rem_in[i] - trial[i]) : rem_in[i];
      prod_next[i] = fits[i] ? (prod_in[i] + (W'(sum_in) << K)) : prod_in[i];
      root_next[i] = root_in[i];
      root_next[i][K] = fits[i];
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_out <= sum_in;
      for (int i = 0; i < NLANE; i++) begin
        rem_out[i]  <= rem_next[i];
        prod_out[i] <= prod_next[i];
        root_out[i] <= root_next[i];
      end
    end
  end

endmodule

FILE: rtl/qnorm_back.sv
// Back end: rounding, sign, identity selection and the output register.
module qnorm_back
  import qnorm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NB        = FRAC_BITS_DEF + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  ctl_t                    ctl,
  input  logic [NB-1:0]           root [NLANE],
  output logic                    out_vld,
  output logic signed [OUT_W-1:0] out_comp [NLANE],
  output logic                    out_degen
);

  localparam int VW = NB + OUT_W;
  localparam logic [OUT_W-1:0] ID_W = OUT_W'(1 << FRAC_BITS);

  logic [NB:0]      root_inc [NLANE];
  logic [VW-1:0]    mag_ext  [NLANE];
  logic [VW-1:0]    val      [NLANE];
  logic [OUT_W-1:0] comp_next [NLANE];

  // Root n is floor(2*|c|*2^F/sqrt(S)); (n+1)/2 rounds |c|*2^F/sqrt(S) half up.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      root_inc[i] = {1'b0, root[i]} + 1'b1;
      mag_ext[i]  = VW'(root_inc[i][NB:1]);
      val[i]      = ctl.neg[i] ? (~mag_ext[i] + 1'b1) : mag_ext[i];
      comp_next[i] = val[i][OUT_W-1:0];
    end
    // Identity quaternion for a degenerate norm.
    if (ctl.degen) begin
      comp_next[0] = '0;
      comp_next[1] = '0;
      comp_next[2] = '0;
      comp_next[3] = ID_W;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_degen <= ctl.degen;
      for (int i = 0; i < NLANE; i++) begin
        out_comp[i] <= comp_next[i];
      end
    end
  end

endmodule

FILE: rtl/quaternion_normalize.sv
// Top level of the pipelined quaternion normalizer.
//
// Channel  Direction  Signals                          Content
// s_*      in         s_tvalid s_tready s_tdata[71:0]  in_x, in_y, in_z, in_w
// m_*      out        m_tvalid m_tready m_tdata[63:0]  out_x, out_y, out_z, out_w
//                     m_tuser[0]                       degenerate
// cfg_*    in         cfg_valid cfg_ready cfg_data     min_norm_sq
//
// One quaternion is accepted per cycle while the output does not stall. The
// pipeline holds two front-end stages, one stage per root bit (FRAC_BITS + 2),
// and the output register. The root-bit stages set the depth.
// Reset clears all valid bits and loads min_norm_sq with 2684.
// A stall on m_tready freezes every stage at once and drops s_tready.
module quaternion_normalize
  import qnorm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [4*IN_W-1:0]      s_tdata,   // in_x, in_y, in_z, in_w from bit 0 up
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [4*OUT_W-1:0]     m_tdata,   // out_x, out_y, out_z, out_w from bit 0 up
  output logic [0:0]             m_tuser,   // degenerate
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int NB = FRAC_BITS + 2;
  localparam int W  = SUM_W + 2 * FRAC_BITS + 4;
  localparam logic [OUT_W-1:0] ID_W = OUT_W'(1 << FRAC_BITS);

  logic             advance;
  logic [CFG_W-1:0] min_norm_sq;

  logic signed [IN_W-1:0]  in_comp  [NLANE];
  logic signed [OUT_W-1:0] out_comp [NLANE];
  logic                    out_degen;

  ctl_t             ctl_s  [NB+1];
  logic [SUM_W-1:0] sum_s  [NB+1];
  logic [W-1:0]     rem_s  [NB+1][NLANE];
  logic [W-1:0]     prod_s [NB+1][NLANE];
  logic [NB-1:0]    root_s [NB+1][NLANE];

  // Threshold register; writes always complete.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm_sq <= MIN_NORM_RESET;
    end else if (cfg_valid) begin
      min_norm_sq <= cfg_data;
    end
  end

  // Whole pipeline moves when the output register is free or being emptied.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Unpack the input transaction.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      in_comp[i] = s_tdata[i*IN_W +: IN_W];
    end
  end

  qnorm_front #(
    .FRAC_BITS (FRAC_BITS),
    .W         (W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .in_vld      (s_tvalid),
    .in_comp     (in_comp),
    .min_norm_sq (min_norm_sq),
    .ctl         (ctl_s[0]),
    .sum         (sum_s[0]),
    .rem         (rem_s[0])
  );

  // The root search starts from zero.
  for (genvar i = 0; i < NLANE; i++) begin : g_seed
    assign prod_s[0][i] = '0;
    assign root_s[0][i] = '0;
  end

  // One stage per root bit, most significant first.
  for (genvar j = 0; j < NB; j++) begin : g_step
    qnorm_step #(
      .W  (W),
      .NB (NB),
      .K  (NB - 1 - j)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .ctl_in   (ctl_s[j]),
      .sum_in   (sum_s[j]),
      .rem_in   (rem_s[j]),
      .prod_in  (prod_s[j]),
      .root_in  (root_s[j]),
      .ctl_out  (ctl_s[j+1]),
      .sum_out  (sum_s[j+1]),
      .rem_out  (rem_s[j+1]),
      .prod_out (prod_s[j+1]),
      .root_out (root_s[j+1])
    );
  end

  qnorm_back #(
    .FRAC_BITS (FRAC_BITS),
    .NB        (NB)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .ctl       (ctl_s[NB]),
    .root      (root_s[NB]),
    .out_vld   (m_tvalid),
    .out_comp  (out_comp),
    .out_degen (out_degen)
  );

  // Pack the output transaction.
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      m_tdata[i*OUT_W +: OUT_W] = out_comp[i];
    end
  end
  assign m_tuser[0] = out_degen;

`ifndef NO_ASSERTIONS
  // A degenerate result carries the identity quaternion.
  a_identity : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (m_tdata[3*OUT_W-1:0] == '0) && (m_tdata[4*OUT_W-1:3*OUT_W] == ID_W))
    else $error("degenerate result is not the identity quaternion");

  // No result is offered in the cycle after a reset edge.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A threshold write lands in the register.
  a_cfg_write : assert property (@(posedge clk) disable iff (rst)
    $past(cfg_valid && !rst) |-> (min_norm_sq == $past(cfg_data)))
    else $error("threshold write lost");
`endif

endmodule

FILE: tb/tb_quaternion_normalize.sv
// Self-checking testbench for the quaternion normalizer stream block.
`timescale 1ns / 1ps

module tb_quaternion_normalize
  import qnorm_pkg::*;
();

  localparam int FRAC    = FRAC_BITS_DEF;
  localparam int ONE     = 1 << FRAC;
  localparam int LATENCY = FRAC + 5;

  // One quaternion as it enters, and one normalized result as it leaves.
  typedef struct {
    logic signed [IN_W-1:0] x, y, z, w;
  } quat_t;

  typedef struct {
    logic signed [OUT_W-1:0] x, y, z, w;
    logic                    degen;
  } unit_quat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [4*IN_W-1:0]      s_tdata = '0;   // in_x, in_y, in_z, in_w from bit 0 up
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [4*OUT_W-1:0]     m_tdata;        // out_x, out_y, out_z, out_w from bit 0 up
  logic [0:0]             m_tuser;        // degenerate
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Local copy of the threshold register and the results still owed by the block.
  logic [CFG_W-1:0] norm_floor = MIN_NORM_RESET;
  unit_quat_t       expected_units[$];

  // Idling controls for the sender and the result sink.
  bit          src_idle = 1'b1;
  bit          snk_idle = 1'b1;
  int unsigned hold_len = 0;

  int unsigned err_count = 0;
  int unsigned n_checked = 0;
  int unsigned n_degen   = 0;
  int unsigned n_writes  = 0;

  quaternion_normalize #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off if it hangs.
  initial begin
    #2_000_000;
    $display("quaternion_normalize regression: fail");
    $finish;
  end

  function automatic quat_t quat(int x, int y, int z, int w);
    quat_t q;
    q.x = IN_W'(x);
    q.y = IN_W'(y);
    q.z = IN_W'(z);
    q.w = IN_W'(w);
    return q;
  endfunction

  // Rounded magnitude of mag * 2^FRAC / sqrt(sumsq): the largest m in [0, ONE] with
  // m = 0 or (2m - 1)^2 * sumsq <= mag^2 * 2^(2*FRAC + 2). Ties round away from zero.
  function automatic longint unsigned scale_component(longint unsigned mag,
                                                      longint unsigned sumsq);
    logic [127:0]    bound;
    logic [127:0]    lhs;
    longint unsigned lo, hi, mid, odd;
    bound = 128'(mag * mag) << (2 * FRAC + 2);
    lo = 0;
    hi = ONE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * mid - 1;
      lhs = 128'(odd * odd) * 128'(sumsq);
      if (lhs <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Expected normalized quaternion under the current threshold.
  function automatic unit_quat_t normalize_quat(quat_t q);
    int              comp[4];
    longint unsigned mag[4];
    longint unsigned sumsq;
    longint unsigned m;
    logic signed [OUT_W-1:0] res[4];
    unit_quat_t      u;
    comp[0] = q.x;
    comp[1] = q.y;
    comp[2] = q.z;
    comp[3] = q.w;
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (comp[i] < 0) ? longint'(-comp[i]) : longint'(comp[i]);
      sumsq += mag[i] * mag[i];
    end
    // A zero quaternion is degenerate even when the threshold is zero.
    if (sumsq == 0 || sumsq < norm_floor) begin
      u.x = '0;
      u.y = '0;
      u.z = '0;
      u.w = OUT_W'(ONE);
      u.degen = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        m = scale_component(mag[i], sumsq);
        res[i] = OUT_W'((comp[i] < 0) ? -longint'(m) : longint'(m));
      end
      u.x = res[0];
      u.y = res[1];
      u.z = res[2];
      u.w = res[3];
      u.degen = 1'b0;
    end
    return u;
  endfunction

  // Random quaternion drawn from several shapes: full range, tiny norms near the
  // threshold, roughly unit length, one dominant axis, and extreme component values.
  function automatic quat_t rand_quat();
    int c[4];
    int kind, amp, lead;
    kind = $urandom_range(0, 5);
    amp  = $urandom_range(0, 1) ? 80 : 700;
    lead = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        1: c[i] = int'($urandom_range(0, 2 * amp)) - amp;
        2: c[i] = int'($urandom_range(0, 2 * ONE)) - ONE;
        3: c[i] = (i == lead) ? int'($urandom_range(0, 262143)) - 131072
                              : int'($urandom_range(0, 16)) - 8;
        4: begin
          case ($urandom_range(0, 5))
            0: c[i] = -131072;
            1: c[i] = 131071;
            2: c[i] = 0;
            3: c[i] = -1;
            4: c[i] = 1;
            default: c[i] = int'($urandom_range(0, 262143)) - 131072;
          endcase
        end
        default: c[i] = int'($urandom_range(0, 262143)) - 131072;
      endcase
    end
    return quat(c[0], c[1], c[2], c[3]);
  endfunction

  // Offers one quaternion and records its expected result once the transaction completes.
  task automatic send_quat(quat_t q);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {q.w, q.z, q.y, q.x};
    do @(posedge clk); while (!s_tready);
    expected_units.push_back(normalize_quat(q));
  endtask

  // Stops offering input and waits until every expected result has arrived.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  // Writes the threshold register while the block is idle.
  task automatic write_floor(logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    norm_floor = value;
    n_writes++;
  endtask

  // Four-state compare so that an unknown output bit counts as a mismatch.
  task automatic compare_field(string name, integer want, integer got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Result sink: checks each output transaction and drives ready with random stalls
  // and, on request, one long hold-off.
  initial begin : result_sink
    int unsigned stall_left;
    unit_quat_t  want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (expected_units.size() == 0) begin
          $error("result with no quaternion pending: data=%h degenerate=%b",
                 m_tdata, m_tuser[0]);
          err_count++;
        end else begin
          want = expected_units.pop_front();
          compare_field("out_x", want.x, $signed(m_tdata[OUT_W-1:0]));
          compare_field("out_y", want.y, $signed(m_tdata[2*OUT_W-1:OUT_W]));
          compare_field("out_z", want.z, $signed(m_tdata[3*OUT_W-1:2*OUT_W]));
          compare_field("out_w", want.w, $signed(m_tdata[4*OUT_W-1:3*OUT_W]));
          compare_field("degenerate", want.degen, m_tuser[0]);
          n_checked++;
          if (want.degen) n_degen++;
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        m_tready <= 1'b0;
      end else begin
        if (stall_left == 0 && snk_idle && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 7);
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Corner quaternions under the threshold loaded at reset.
  task automatic test_reset_floor();
    send_quat(quat(0, 0, 0, 0));
    send_quat(quat(0, 0, 0, ONE));
    send_quat(quat(ONE, 0, 0, 0));
    send_quat(quat(131071, 131071, 131071, 131071));
    send_quat(quat(-131072, -131072, -131072, -131072));
    send_quat(quat(-131072, 0, 0, 0));
    send_quat(quat(0, 131071, 0, 0));
    send_quat(quat(0, 0, -1, 0));
    // Squared norm exactly at the threshold, then just below it.
    send_quat(quat(50, 12, 6, 2));
    send_quat(quat(50, 12, 6, 1));
    send_quat(quat(-131072, 131071, -1, 1));
    send_quat(quat(1, -1, 1, -1));
    send_quat(quat(3 * 4096, -4 * 4096, 0, 0));
  endtask

  // Lowest and highest threshold settings.
  task automatic test_floor_extremes();
    write_floor('0);
    send_quat(quat(0, 0, 0, 0));
    send_quat(quat(0, 0, 0, 1));
    send_quat(quat(1, 1, 1, 1));
    send_quat(quat(-1, 0, 0, 0));
    write_floor({CFG_W{1'b1}});
    send_quat(quat(1024, 0, 0, 0));
    send_quat(quat(1023, 45, 0, 0));
    send_quat(quat(1023, 46, 0, 0));
    send_quat(quat(0, 0, 0, -1024));
  endtask

  // Random quaternions under a series of thresholds, with idling on both sides.
  task automatic test_random_floors();
    logic [CFG_W-1:0] floor_val;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: floor_val = MIN_NORM_RESET;
        1: floor_val = CFG_W'($urandom_range(0, 20000));
        2: floor_val = CFG_W'($urandom);
        3: floor_val = '0;
        default: floor_val = {CFG_W{1'b1}};
      endcase
      write_floor(floor_val);
      repeat (160) send_quat(rand_quat());
    end
    drain();
  endtask

  // The sink holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and input ready must drop.
  task automatic test_output_hold();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    hold_len = 200;
    repeat (60) send_quat(rand_quat());
    drain();
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // Back-to-back traffic with no idling at all.
  task automatic test_steady_stream();
    write_floor(MIN_NORM_RESET);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (100) send_quat(rand_quat());
    drain();
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_floor();
    test_floor_extremes();
    test_random_floors();
    test_output_hold();
    test_steady_stream();
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    $display("Checked %0d normalized quaternions, %0d of them degenerate,", n_checked, n_degen);
    $display("across %0d threshold writes with stalls on both sides and a long output hold.",
             n_writes);
    if (err_count == 0 && expected_units.size() == 0) begin
      $display("quaternion_normalize regression: pass");
    end else begin
      $display("quaternion_normalize regression: fail");
    end
    $finish;
  end

endmodule
